// File: rtl/icu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icu_pkg
// Shared types and constants of the interlaced 4:2:0 to 4:2:2 chroma upsampler.
// ----------------------------------------------------------------------------
package icu_pkg;

  localparam int unsigned SampleW   = 8;
  localparam int unsigned OutRowW   = 12;
  localparam int unsigned OutColW   = 10;
  localparam int unsigned RowWidthW = 11;
  localparam int unsigned SrcRowsW  = 12;
  localparam int unsigned CfgDataW  = 12;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [CfgIdxW-1:0] RegRowWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSourceRows = 1'b1;

  localparam logic [RowWidthW-1:0] RowWidthReset = 11'd360;
  localparam logic [SrcRowsW-1:0]  SrcRowsReset  = 12'd288;

  localparam int unsigned MinRows = 4;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  localparam logic [10:0] RoundBias = 11'd4;
  localparam int unsigned WeightShift = 3;

  typedef enum logic [1:0] {
    KIND_COPY,
    KIND_EVEN,
    KIND_ODD
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic                tail;
    logic [SampleW-1:0]  cur;
    logic [SampleW-1:0]  prev;
    logic [OutRowW-1:0]  row;
    logic [OutRowW-1:0]  tail_row;
    logic [OutColW-1:0]  col;
  } job_t;

endpackage
`default_nettype wire

// File: rtl/icu_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icu_if
// Valid/ready channels for source chroma samples and addressed output samples.
// ----------------------------------------------------------------------------
interface icu_sample_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface icu_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  value;
  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic        run_end;

  modport source (output valid, output value, output out_row, output out_col,
                  output run_end, input ready);
  modport sink   (input valid, input value, input out_row, input out_col,
                  input run_end, output ready);
endinterface
`default_nettype wire

// File: rtl/interlaced_chroma_420_to_422.sv
`default_nettype none
// ----------------------------------------------------------------------------
// interlaced_chroma_420_to_422
// Interlaced 4:2:0 to 4:2:2 chroma upsampler: per-field vertical doubling
// with eighth-step weights, results tagged with output row and column.
//
//   channel    dir   handshake        payload
//   sample_i   in    valid / ready    sample
//   result_o   out   valid / ready    value, out_row, out_col, run_end
//   cfg        in    cfg_we_i         cfg_idx_i, cfg_data_i
//
// One result leaves per cycle on result_o unless it is stalled; a sample
// yields one result in rows 0 and 1, two in middle rows and three in the
// last two rows. Results pass the line store read register, the job queue
// and the output register. A four-entry job queue lets the front keep
// taking samples while the output is stalled. Reset clears counters and
// control only; the line store is filled by rows 0 and 1 of each frame.
// ----------------------------------------------------------------------------
module interlaced_chroma_420_to_422
  import icu_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_ROWS  = 2048
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  icu_sample_if.sink               sample_i,
  icu_result_if.source             result_o
);

  logic job_valid, job_ready;
  job_t job_in;
  logic head_valid, head_pop;
  job_t head_job;

  icu_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_ROWS  (MAX_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (sample_i),
    .job_valid_o (job_valid),
    .job_o       (job_in),
    .job_ready_i (job_ready)
  );

  icu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_job_i   (job_in),
    .pop_valid_o  (head_valid),
    .pop_i        (head_pop),
    .pop_job_o    (head_job)
  );

  icu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .job_pop_o   (head_pop),
    .result_o    (result_o)
  );

endmodule
`default_nettype wire

// File: rtl/icu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icu_front
// Accepts samples, tracks row and column, swaps the line store entry and
// classifies each sample into a job for the back end.
// ----------------------------------------------------------------------------
module icu_front
  import icu_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_ROWS  = 2048
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  icu_sample_if.sink               sample_i,
  output logic                     job_valid_o,
  output job_t                     job_o,
  input  wire logic                job_ready_i
);

  localparam int unsigned ColW   = $clog2(MAX_WIDTH);
  localparam int unsigned RowW   = $clog2(MAX_ROWS);
  localparam int unsigned AddrW  = $clog2(2 * MAX_WIDTH);
  localparam int unsigned Depth  = 2 * MAX_WIDTH;
  localparam logic [31:0] MaxW   = 32'(MAX_WIDTH);
  localparam logic [31:0] RowLim = 32'(MAX_ROWS) & ~32'd1;

  logic [RowWidthW-1:0] row_width_q;
  logic [SrcRowsW-1:0]  src_rows_q;
  logic [ColW-1:0]      col_q;
  logic [RowW-1:0]      row_q;

  logic [31:0]          w32, r32;
  logic [ColW:0]        eff_w;
  logic [RowW:0]        eff_r;
  logic                 accept;
  logic                 col_wrap, row_wrap;
  logic [AddrW-1:0]     addr;

  logic [SampleW-1:0]   store_q [Depth];
  logic [SampleW-1:0]   prev_q;
  logic                 s1_valid_q;
  job_t                 s1_job_q;
  job_t                 job_d;

  always_comb begin
    w32 = {21'b0, row_width_q};
    if (w32 == 32'd0) begin
      w32 = 32'd1;
    end
    if (w32 > MaxW) begin
      w32 = MaxW;
    end
    r32 = {20'b0, src_rows_q[SrcRowsW-1:1], 1'b0};
    if (r32 < 32'(MinRows)) begin
      r32 = 32'(MinRows);
    end
    if (r32 > RowLim) begin
      r32 = RowLim;
    end
    eff_w = (ColW+1)'(w32);
    eff_r = (RowW+1)'(r32);
  end

  assign sample_i.ready = !s1_valid_q || job_ready_i;
  assign accept         = sample_i.valid && sample_i.ready;
  assign col_wrap       = {1'b0, col_q} == eff_w - (ColW+1)'(1);
  assign row_wrap       = {1'b0, row_q} == eff_r - (RowW+1)'(1);
  assign addr           = row_q[0] ? AddrW'(MAX_WIDTH) + AddrW'(col_q) : AddrW'(col_q);

  always_comb begin
    job_d.cur      = sample_i.sample;
    job_d.prev     = '0;
    job_d.row      = OutRowW'(row_q);
    job_d.col      = OutColW'(col_q);
    job_d.tail     = {1'b0, row_q} >= eff_r - (RowW+1)'(2);
    job_d.tail_row = OutRowW'((RowW+2)'(row_q) + (RowW+2)'(eff_r));
    if (row_q < RowW'(2)) begin
      job_d.kind = KIND_COPY;
    end else if (row_q[0]) begin
      job_d.kind = KIND_ODD;
    end else begin
      job_d.kind = KIND_EVEN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= RowWidthReset;
      src_rows_q  <= SrcRowsReset;
      col_q       <= '0;
      row_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRowWidth:   row_width_q <= cfg_data_i[RowWidthW-1:0];
        RegSourceRows: src_rows_q  <= cfg_data_i[SrcRowsW-1:0];
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : row_q + RowW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  // swap: read the stored sample of this field, write the new one
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_q        <= store_q[addr];
      store_q[addr] <= sample_i.sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      s1_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_job_q <= job_d;
    end
  end

  always_comb begin
    job_o      = s1_job_q;
    job_o.prev = prev_q;
  end

  assign job_valid_o = s1_valid_q;

endmodule
`default_nettype wire

// File: rtl/icu_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icu_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module icu_queue
  import icu_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire job_t  push_job_i,
  output logic       pop_valid_o,
  input  wire logic  pop_i,
  output job_t       pop_job_o
);

  job_t                 slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q;
  logic                 push, pop;

  assign push_ready_o = count_q != (QueuePtrW+1)'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_job_o    = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   count_q <= count_q + (QueuePtrW+1)'(1);
        2'b01:   count_q <= count_q - (QueuePtrW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/icu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icu_back
// Expands each job into one to three output samples through an output
// register.
// ----------------------------------------------------------------------------
module icu_back
  import icu_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  job_valid_i,
  input  wire job_t  job_i,
  output logic       job_pop_o,
  icu_result_if.source result_o
);

  logic [1:0]          phase_q;
  logic [1:0]          n_res;
  logic                last;
  logic                emit;
  logic [3:0]          wp;
  logic [10:0]         sum;
  logic [SampleW-1:0]  value_d;
  logic [OutRowW-1:0]  row_d;
  logic [OutRowW-1:0]  row2;

  logic                valid_q;
  logic [SampleW-1:0]  value_q;
  logic [OutRowW-1:0]  row_q;
  logic [OutColW-1:0]  col_q;
  logic                end_q;

  assign n_res = (job_i.kind == KIND_COPY ? 2'd1 : 2'd2) + {1'b0, job_i.tail};
  assign last  = phase_q == n_res - 2'd1;
  assign emit  = job_valid_i && (!valid_q || result_o.ready);
  assign row2  = {job_i.row[OutRowW-2:0], 1'b0};
  assign sum   = 11'(wp) * 11'(job_i.prev) + 11'(4'd8 - wp) * 11'(job_i.cur) + RoundBias;

  always_comb begin
    unique case (job_i.kind)
      KIND_EVEN: wp = (phase_q == 2'd0) ? 4'd5 : 4'd1;
      KIND_ODD:  wp = (phase_q == 2'd0) ? 4'd7 : 4'd3;
      default:   wp = 4'd0;
    endcase
    priority if (job_i.tail && last) begin
      value_d = job_i.cur;
      row_d   = job_i.tail_row;
    end else if (job_i.kind == KIND_COPY) begin
      value_d = job_i.cur;
      row_d   = job_i.row;
    end else begin
      value_d = SampleW'(sum >> WeightShift);
      unique case (job_i.kind)
        KIND_EVEN: row_d = (phase_q == 2'd0) ? row2 - OutRowW'(2) : row2;
        default:   row_d = (phase_q == 2'd0) ? row2 - OutRowW'(3) : row2 - OutRowW'(1);
      endcase
    end
  end

  assign job_pop_o = emit && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (emit) begin
        phase_q <= last ? 2'd0 : phase_q + 2'd1;
        valid_q <= 1'b1;
      end else if (result_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      value_q <= value_d;
      row_q   <= row_d;
      col_q   <= job_i.col;
      end_q   <= last;
    end
  end

  assign result_o.valid   = valid_q;
  assign result_o.value   = value_q;
  assign result_o.out_row = row_q;
  assign result_o.out_col = col_q;
  assign result_o.run_end = end_q;

endmodule
`default_nettype wire
